// ----- hdl/svc_pkg.sv -----
`timescale 1ns / 1ps

package svc_pkg;

  // Fixed field and register widths.
  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned SIZE_X_W  = 7;
  localparam int unsigned SIZE_Y_W  = 11;
  localparam int unsigned SIZE_Z_W  = 7;
  localparam int unsigned APB_AW    = 5;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned LANES     = 3;
  localparam int unsigned IN_DATA_W  = 4 * FIELD_W;
  localparam int unsigned OUT_DATA_W = LANES * FIELD_W;

  // Fixed-point rounding of the Q32.32 product back to Q16.16.
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned ROUND_BIAS = 1 << (FRAC_BITS - 1);

  // Defaults of the top-level parameters.
  localparam int unsigned MAX_X_DEF       = 64;
  localparam int unsigned MAX_Y_DEF       = 1024;
  localparam int unsigned MAX_Z_DEF       = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Register reset values.
  localparam logic [SIZE_X_W-1:0] SIZE_X_RST = SIZE_X_W'(64);
  localparam logic [SIZE_Y_W-1:0] SIZE_Y_RST = SIZE_Y_W'(64);
  localparam logic [SIZE_Z_W-1:0] SIZE_Z_RST = SIZE_Z_W'(64);

  typedef enum logic [2:0] {
    REG_COEF_X,
    REG_COEF_Y,
    REG_COEF_Z,
    REG_SIZE_X,
    REG_SIZE_Y,
    REG_SIZE_Z
  } reg_idx_e;

  typedef struct packed {
    logic [COEF_W-1:0]   coef_x;
    logic [COEF_W-1:0]   coef_y;
    logic [COEF_W-1:0]   coef_z;
    logic [SIZE_X_W-1:0] size_x;
    logic [SIZE_Y_W-1:0] size_y;
    logic [SIZE_Z_W-1:0] size_z;
  } cfg_t;

  typedef struct packed {
    logic first_x;
    logic first_y;
    logic first_z;
    logic grid_last;
  } cell_flags_t;

endpackage

// ----- hdl/svc_ram.sv -----
`timescale 1ns / 1ps

module svc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr0_i,
  input  logic [AW-1:0]    raddr1_i,
  output logic [WIDTH-1:0] rdata0_o,
  output logic [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

// ----- hdl/svc_regs.sv -----
`timescale 1ns / 1ps

module svc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [svc_pkg::APB_AW-1:0]  paddr,
  input  logic [svc_pkg::APB_DW-1:0]  pwdata,
  output logic [svc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output svc_pkg::cfg_t               cfg_o
);

  import svc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_COEF_X: cfg_d.coef_x = pwdata[COEF_W-1:0];
        REG_COEF_Y: cfg_d.coef_y = pwdata[COEF_W-1:0];
        REG_COEF_Z: cfg_d.coef_z = pwdata[COEF_W-1:0];
        REG_SIZE_X: cfg_d.size_x = pwdata[SIZE_X_W-1:0];
        REG_SIZE_Y: cfg_d.size_y = pwdata[SIZE_Y_W-1:0];
        REG_SIZE_Z: cfg_d.size_z = pwdata[SIZE_Z_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COEF_X: prdata = APB_DW'(cfg_q.coef_x);
      REG_COEF_Y: prdata = APB_DW'(cfg_q.coef_y);
      REG_COEF_Z: prdata = APB_DW'(cfg_q.coef_z);
      REG_SIZE_X: prdata = APB_DW'(cfg_q.size_x);
      REG_SIZE_Y: prdata = APB_DW'(cfg_q.size_y);
      REG_SIZE_Z: prdata = APB_DW'(cfg_q.size_z);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_x <= '0;
      cfg_q.coef_y <= '0;
      cfg_q.coef_z <= '0;
      cfg_q.size_x <= SIZE_X_RST;
      cfg_q.size_y <= SIZE_Y_RST;
      cfg_q.size_z <= SIZE_Z_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- hdl/svc_scan.sv -----
`timescale 1ns / 1ps

module svc_scan #(
  parameter int unsigned MAX_X = 64,
  parameter int unsigned MAX_Y = 1024,
  parameter int unsigned MAX_Z = 64,
  localparam int unsigned AW = $clog2(MAX_X * MAX_Z)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic [svc_pkg::SIZE_X_W-1:0]  size_x_i,
  input  logic [svc_pkg::SIZE_Y_W-1:0]  size_y_i,
  input  logic [svc_pkg::SIZE_Z_W-1:0]  size_z_i,
  output logic [AW-1:0]                 here_o,
  output logic [AW-1:0]                 xnb_o,
  output svc_pkg::cell_flags_t          flags_o
);

  import svc_pkg::*;

  localparam int unsigned XW = $clog2(MAX_X);
  localparam int unsigned YW = $clog2(MAX_Y);
  localparam int unsigned ZW = $clog2(MAX_Z);

  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic [ZW-1:0] z_q, z_d;
  // here_q = x*MAX_Z + z, xnb_q = here_q - MAX_Z, xbase_q = x*MAX_Z.
  logic [AW-1:0] here_q, here_d;
  logic [AW-1:0] xnb_q, xnb_d;
  logic [AW-1:0] xbase_q, xbase_d;

  logic [XW:0] sx;
  logic [YW:0] sy;
  logic [ZW:0] sz;
  logic        lx, ly, lz;

  // A size of zero counts as one, a size above the maximum as the maximum.
  always_comb begin
    if (size_x_i == '0) begin
      sx = (XW+1)'(1);
    end else if (32'(size_x_i) > MAX_X) begin
      sx = (XW+1)'(MAX_X);
    end else begin
      sx = (XW+1)'(size_x_i);
    end
    if (size_y_i == '0) begin
      sy = (YW+1)'(1);
    end else if (32'(size_y_i) > MAX_Y) begin
      sy = (YW+1)'(MAX_Y);
    end else begin
      sy = (YW+1)'(size_y_i);
    end
    if (size_z_i == '0) begin
      sz = (ZW+1)'(1);
    end else if (32'(size_z_i) > MAX_Z) begin
      sz = (ZW+1)'(MAX_Z);
    end else begin
      sz = (ZW+1)'(size_z_i);
    end
  end

  assign lx = (32'(x_q) + 32'd1) >= 32'(sx);
  assign ly = (32'(y_q) + 32'd1) >= 32'(sy);
  assign lz = (32'(z_q) + 32'd1) >= 32'(sz);

  always_comb begin
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    here_d  = here_q;
    xnb_d   = xnb_q;
    xbase_d = xbase_q;
    if (adv_i) begin
      if (!lz) begin
        z_d    = z_q + ZW'(1);
        here_d = here_q + AW'(1);
        xnb_d  = xnb_q + AW'(1);
      end else begin
        z_d = '0;
        if (!lx) begin
          x_d     = x_q + XW'(1);
          here_d  = xbase_q + AW'(MAX_Z);
          xnb_d   = xbase_q;
          xbase_d = xbase_q + AW'(MAX_Z);
        end else begin
          // The x neighbor address is unused on the first x face.
          x_d     = '0;
          here_d  = '0;
          xnb_d   = '0;
          xbase_d = '0;
          y_d     = ly ? '0 : y_q + YW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      here_q  <= '0;
      xnb_q   <= '0;
      xbase_q <= '0;
    end else begin
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      here_q  <= here_d;
      xnb_q   <= xnb_d;
      xbase_q <= xbase_d;
    end
  end

  assign here_o            = here_q;
  assign xnb_o             = xnb_q;
  assign flags_o.first_x   = (x_q == '0);
  assign flags_o.first_y   = (y_q == '0);
  assign flags_o.first_z   = (z_q == '0);
  assign flags_o.grid_last = lx & ly & lz;

endmodule

// ----- hdl/svc_corr.sv -----
`timescale 1ns / 1ps

module svc_corr #(
  parameter int unsigned VW = 32
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            in_valid_i,
  output logic                                            in_ready_o,
  input  logic [VW-1:0]                                   p_i,
  input  logic [svc_pkg::LANES-1:0][VW-1:0]               star_i,
  input  svc_pkg::cell_flags_t                            flags_i,
  // Memory read data for the item held in the first stage.
  input  logic [VW-1:0]                                   nb_x_i,
  input  logic [VW-1:0]                                   nb_y_i,
  input  logic [svc_pkg::LANES-1:0][svc_pkg::COEF_W-1:0]  coef_i,
  output logic                                            out_valid_o,
  input  logic                                            out_ready_i,
  output logic [svc_pkg::LANES-1:0][svc_pkg::FIELD_W-1:0] out_data_o,
  output logic                                            out_last_o
);

  import svc_pkg::*;

  localparam int unsigned PW = VW + COEF_W;      // product
  localparam int unsigned CW = PW - FRAC_BITS;   // rounded correction
  localparam int unsigned RW = VW + 18;          // star +/- correction

  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
  logic va_q, vb_q, vc_q, vd_q, ve_q;

  // Stage A: captured beat, memory read in flight.
  logic [VW-1:0]            pa_q, pza_q, last_p_q;
  logic [LANES-1:0][VW-1:0] stara_q;
  cell_flags_t              fa_q;

  // Stage B: magnitude and sign of the pressure difference.
  logic [LANES-1:0][VW-1:0] magb_q, magb_d;
  logic [LANES-1:0]         negb_q, negb_d;
  logic [LANES-1:0][VW-1:0] starb_q;
  cell_flags_t              fb_q;
  logic [LANES-1:0][VW-1:0] nb;
  logic [LANES-1:0][VW:0]   dif_pn, dif_np;

  // Stage C: product.
  logic [LANES-1:0][PW-1:0] prodc_q, prodc_d;
  logic [LANES-1:0]         negc_q;
  logic [LANES-1:0][VW-1:0] starc_q;
  cell_flags_t              fc_q;

  // Stage D: rounded correction.
  logic [LANES-1:0][CW-1:0] corrd_q, corrd_d;
  logic [LANES-1:0][PW-1:0] rsum;
  logic [LANES-1:0]         negd_q;
  logic [LANES-1:0][VW-1:0] stard_q;
  cell_flags_t              fd_q;

  // Stage E: output register.
  logic [LANES-1:0][FIELD_W-1:0] oute_q, oute_d;
  logic                          laste_q;
  logic [LANES-1:0][RW-1:0]      rs, rc, rr;
  logic [LANES-1:0]              zero_lane;
  logic signed [VW-1:0]          sat [LANES];

  assign rdy_e = !ve_q || out_ready_i;
  assign rdy_d = !vd_q || rdy_e;
  assign rdy_c = !vc_q || rdy_d;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;
  assign in_ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= in_valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
      if (rdy_c) begin
        vc_q <= vb_q;
      end
      if (rdy_d) begin
        vd_q <= vc_q;
      end
      if (rdy_e) begin
        ve_q <= vd_q;
      end
    end
  end

  // The z neighbor is the pressure of the beat just before.
  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      pa_q     <= p_i;
      stara_q  <= star_i;
      fa_q     <= flags_i;
      pza_q    <= last_p_q;
      last_p_q <= p_i;
    end
  end

  assign nb[0] = nb_x_i;
  assign nb[1] = nb_y_i;
  assign nb[2] = pza_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      dif_pn[l] = {pa_q[VW-1], pa_q} - {nb[l][VW-1], nb[l]};
      dif_np[l] = {nb[l][VW-1], nb[l]} - {pa_q[VW-1], pa_q};
      negb_d[l] = dif_pn[l][VW];
      magb_d[l] = dif_pn[l][VW] ? dif_np[l][VW-1:0] : dif_pn[l][VW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b) begin
      magb_q  <= magb_d;
      negb_q  <= negb_d;
      starb_q <= stara_q;
      fb_q    <= fa_q;
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      prodc_d[l] = PW'(magb_q[l]) * PW'(coef_i[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c) begin
      prodc_q <= prodc_d;
      negc_q  <= negb_q;
      starc_q <= starb_q;
      fc_q    <= fb_q;
    end
  end

  // Round to nearest, ties away from zero, on the magnitude.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rsum[l]    = prodc_q[l] + PW'(ROUND_BIAS);
      corrd_d[l] = rsum[l][PW-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d) begin
      corrd_q <= corrd_d;
      negd_q  <= negc_q;
      stard_q <= starc_q;
      fd_q    <= fc_q;
    end
  end

  assign zero_lane = {fd_q.first_z, fd_q.first_y, fd_q.first_x};

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rs[l] = {{(RW-VW){stard_q[l][VW-1]}}, stard_q[l]};
      rc[l] = RW'(corrd_q[l]);
      rr[l] = negd_q[l] ? rs[l] + rc[l] : rs[l] - rc[l];
      if ((rr[l][RW-1:VW-1] == '0) || (rr[l][RW-1:VW-1] == '1)) begin
        sat[l] = rr[l][VW-1:0];
      end else if (rr[l][RW-1]) begin
        sat[l] = {1'b1, {(VW-1){1'b0}}};
      end else begin
        sat[l] = {1'b0, {(VW-1){1'b1}}};
      end
      oute_d[l] = zero_lane[l] ? '0 : FIELD_W'(sat[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_e) begin
      oute_q  <= oute_d;
      laste_q <= fd_q.grid_last;
    end
  end

  assign out_valid_o = ve_q;
  assign out_data_o  = oute_q;
  assign out_last_o  = laste_q;

endmodule

// ----- hdl/staggered_velocity_correction_core.sv -----
`timescale 1ns / 1ps

// Velocity correction for a projection solver on a staggered 3-D grid.
// Input stream: one beat per cell in scan order (y outermost, then x, then z),
// carrying the cell pressure and the three provisional velocities. Output
// stream: one beat per input beat with the corrected velocities; tlast marks
// the last cell of the grid. Each component is zero on the first face of
// its own axis and saturates to the signed value range.
// Coefficients and grid sizes are to be set through the APB port while the
// block is idle; the block does not enforce this. A size of zero acts as one,
// a size above the maximum as the maximum. Throughput is one cell per clock
// while the receiver keeps up. The pressure plane memory is read at the x and y
// neighbors and written with the new pressure in the same cycle, and the z
// neighbor is kept in a register, so no cell waits on the one before. Up to five
// beats are in flight. When the receiver stalls, the pipeline fills and
// s_axis_tready falls only once every stage holds a beat.
// Reset clears the scan position to the grid origin, the coefficients to zero
// and the sizes to 64. The plane memory is not cleared: every entry is written
// by the first plane before it is read.
module staggered_velocity_correction_core #(
  parameter int unsigned MAX_X       = svc_pkg::MAX_X_DEF,
  parameter int unsigned MAX_Y       = svc_pkg::MAX_Y_DEF,
  parameter int unsigned MAX_Z       = svc_pkg::MAX_Z_DEF,
  parameter int unsigned VALUE_WIDTH = svc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pressure, u_star, v_star, w_star (32 bits each)
  input  logic [svc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // u_new, v_new, w_new (32 bits each)
  output logic [svc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // grid_done
  output logic                            m_axis_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [svc_pkg::APB_AW-1:0]      paddr,
  input  logic [svc_pkg::APB_DW-1:0]      pwdata,
  output logic [svc_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);

  import svc_pkg::*;

  localparam int unsigned VW    = (VALUE_WIDTH > FIELD_W) ? FIELD_W : VALUE_WIDTH;
  localparam int unsigned DEPTH = MAX_X * MAX_Z;
  localparam int unsigned AW    = $clog2(DEPTH);

  cfg_t                       cfg;
  cell_flags_t                flags;
  logic [AW-1:0]              here, xnb;
  logic                       acc;
  logic [VW-1:0]              p_in;
  logic [LANES-1:0][VW-1:0]   star_in;
  logic [VW-1:0]              nb_x, nb_y;
  logic [LANES-1:0][COEF_W-1:0] coef;

  assign acc  = s_axis_tvalid & s_axis_tready;
  assign p_in = s_axis_tdata[VW-1:0];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      star_in[l] = s_axis_tdata[(l+1)*FIELD_W +: VW];
    end
  end

  assign coef[0] = cfg.coef_x;
  assign coef[1] = cfg.coef_y;
  assign coef[2] = cfg.coef_z;

  svc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  svc_scan #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (acc),
    .size_x_i (cfg.size_x),
    .size_y_i (cfg.size_y),
    .size_z_i (cfg.size_z),
    .here_o   (here),
    .xnb_o    (xnb),
    .flags_o  (flags)
  );

  // Port 1 reads the cell's own entry before it is overwritten: that is the
  // pressure of the same x,z one plane back in y.
  svc_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_plane (
    .clk_i    (clk_i),
    .we_i     (acc),
    .waddr_i  (here),
    .wdata_i  (p_in),
    .re_i     (acc),
    .raddr0_i (xnb),
    .raddr1_i (here),
    .rdata0_o (nb_x),
    .rdata1_o (nb_y)
  );

  svc_corr #(
    .VW (VW)
  ) u_corr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .p_i         (p_in),
    .star_i      (star_in),
    .flags_i     (flags),
    .nb_x_i      (nb_x),
    .nb_y_i      (nb_y),
    .coef_i      (coef),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // Input back-pressure only ever comes from a stalled output beat.
  a_ready_from_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a stalled output beat");

  a_addr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> (32'(here) < DEPTH))
    else $error("plane address beyond memory depth");

  a_grid_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && flags.grid_last) |=> (here == '0 && xnb == '0 && flags.first_y))
    else $error("scan did not return to the origin after the last cell");

endmodule
